@@ rtl/nsp_pkg.sv @@
// Shared types and constants for the note sequence player.
// Holds the item structs, operation, mode and register codes and the speed table.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package nsp_pkg;

  // Operation codes of an input item.
  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_START = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;

  // Playback modes.
  localparam logic [1:0] MODE_LOAD = 2'd0;
  localparam logic [1:0] MODE_NOTE = 2'd1;
  localparam logic [1:0] MODE_GAP  = 2'd2;
  localparam logic [1:0] MODE_END  = 2'd3;

  // Configuration register indexes.
  localparam logic [2:0] REG_NOTE_UNIT = 3'd0;
  localparam logic [2:0] REG_GAP       = 3'd1;
  localparam logic [2:0] REG_REST_NOTE = 3'd2;
  localparam logic [2:0] REG_DB_PERIOD = 3'd3;
  localparam logic [2:0] REG_DB_COUNT  = 3'd4;

  // Half-millisecond steps for 0.5x, 1x, 2x and 4x.
  localparam logic [3:0] SPEED_STEPS [4] = '{4'd1, 4'd2, 4'd4, 4'd8};

  // Percent scale and the width of played_ms * 100 plus rounding.
  localparam logic [6:0] PCT_SCALE = 7'd100;
  localparam int         NUM_W     = 39;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] note_in;
    logic [7:0] length_in;
    logic       key_pause_down;
    logic       key_speed_down;
  } in_item_t;

  typedef struct packed {
    logic [7:0] note_out;
    logic       tone_on;
    logic [1:0] mode;
    logic       is_paused;
    logic [6:0] percent;
    logic [2:0] speed_level;
  } out_item_t;

endpackage

`default_nettype wire

@@ rtl/note_sequence_player_unit.sv @@
// Note sequence player: score store, playback sequencer and serial percent divider.
// Depends on nsp_pkg. A load goes to the percent step directly; a tick runs up to four substeps,
// each of which may load a note; a start first sums the time of all entries, then loads the first note.
// End mode skips the percent divider. A new transfer is taken at the edge that ends
// the strobe cycle; the receiver cannot stall. Synchronous reset clears all state but the
// score store, num_r, quo_r and out_data_r; there is no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module note_sequence_player_unit #(
  parameter int MAX_ENTRIES = 128
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire nsp_pkg::in_item_t  in_data,
  output logic                    out_valid,
  output nsp_pkg::out_item_t      out_data,
  input  wire logic               cfg_we,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [7:0]         cfg_wdata
);
  import nsp_pkg::*;

  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_ENTRIES);

  typedef enum logic [3:0] {
    S_IDLE, S_TOT_RD, S_TOT_ACC, S_LD_RD, S_LD_APPLY,
    S_SUB, S_PCT_MUL, S_PCT_DIV, S_DONE
  } state_t;

  // Score store.
  logic [15:0]   score_mem [MAX_ENTRIES];
  logic [15:0]   rd_data_r;
  logic [AW-1:0] rd_addr;
  logic          mem_we;

  state_t        state_r, state_nxt;
  logic [7:0]    unit_r, unit_nxt, gap_cfg_r, gap_cfg_nxt, rest_r, rest_nxt;
  logic [3:0]    period_r, period_nxt;
  logic [2:0]    dbcnt_r, dbcnt_nxt;
  logic [CW-1:0] entry_count_r, entry_count_nxt, read_pos_r, read_pos_nxt, idx_r, idx_nxt;
  logic [1:0]    mode_r, mode_nxt;
  logic          pause_r, pause_nxt;
  logic [7:0]    note_r, note_nxt;
  logic [15:0]   note_left_r, note_left_nxt;
  logic [7:0]    gap_left_r, gap_left_nxt;
  logic [31:0]   played_r, played_nxt, total_r, total_nxt, sum_r, sum_nxt;
  logic [1:0]    speed_r, speed_nxt;
  logic [3:0]    acc_r, acc_nxt;
  logic [3:0]    sdiv_r, sdiv_nxt;
  logic [2:0]    pcnt_r, pcnt_nxt, scnt_r, scnt_nxt;
  logic          plock_r, plock_nxt, slock_r, slock_nxt;
  logic [NUM_W-1:0] num_r, num_nxt;
  logic [6:0]    quo_r, quo_nxt;
  logic [2:0]    bit_r, bit_nxt;
  logic          out_valid_r, out_valid_nxt;
  out_item_t     out_data_r, out_data_nxt;

  // Shared 8x8 multiplier for entry time and note length.
  logic [15:0]      unit_prod;
  logic [NUM_W-1:0] pct_prod, trial;
  logic [3:0]       sdiv_inc;
  logic             accept;

  assign unit_prod = {8'd0, unit_r} * {8'd0, rd_data_r[7:0]};
  assign pct_prod  = {7'd0, played_r} * NUM_W'(PCT_SCALE);
  assign trial     = {7'd0, total_r} << bit_r;
  assign sdiv_inc  = sdiv_r + 4'd1;
  assign accept    = start && !busy;
  assign rd_addr   = (state_r == S_TOT_RD) ? idx_r[AW-1:0] : read_pos_r[AW-1:0];
  assign mem_we    = accept && (in_data.op == OP_LOAD) && (entry_count_r < MAX_CNT);

  // Store write and registered read.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      score_mem[entry_count_r[AW-1:0]] <= {in_data.note_in, in_data.length_in};
    end
    rd_data_r <= score_mem[rd_addr];
  end

  // Sequencer next-state logic.
  always_comb begin
    state_nxt = state_r;
    unit_nxt = unit_r;         gap_cfg_nxt = gap_cfg_r;   rest_nxt = rest_r;
    period_nxt = period_r;     dbcnt_nxt = dbcnt_r;
    entry_count_nxt = entry_count_r; read_pos_nxt = read_pos_r; idx_nxt = idx_r;
    mode_nxt = mode_r;         pause_nxt = pause_r;       note_nxt = note_r;
    note_left_nxt = note_left_r; gap_left_nxt = gap_left_r;
    played_nxt = played_r;     total_nxt = total_r;       sum_nxt = sum_r;
    speed_nxt = speed_r;       acc_nxt = acc_r;           sdiv_nxt = sdiv_r;
    pcnt_nxt = pcnt_r;         scnt_nxt = scnt_r;
    plock_nxt = plock_r;       slock_nxt = slock_r;
    num_nxt = num_r;           quo_nxt = quo_r;           bit_nxt = bit_r;
    out_valid_nxt = 1'b0;      out_data_nxt = out_data_r;

    // Configuration writes.
    if (cfg_we) begin
      unique case (cfg_index)
        REG_NOTE_UNIT: unit_nxt = cfg_wdata;
        REG_GAP:       gap_cfg_nxt = cfg_wdata;
        REG_REST_NOTE: rest_nxt = cfg_wdata;
        REG_DB_PERIOD: period_nxt = cfg_wdata[3:0];
        REG_DB_COUNT:  dbcnt_nxt = cfg_wdata[2:0];
        default: ;
      endcase
    end

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_PCT_MUL;
          unique case (in_data.op)
            OP_LOAD: begin
              if (entry_count_r < MAX_CNT) entry_count_nxt = entry_count_r + 1'b1;
            end
            OP_START: begin
              read_pos_nxt = '0;
              played_nxt = '0;
              acc_nxt = '0;
              sum_nxt = '0;
              idx_nxt = '0;
              state_nxt = S_TOT_RD;
            end
            OP_TICK: begin
              // Key sampling and debounce.
              if (sdiv_inc < period_r) begin
                sdiv_nxt = sdiv_inc;
              end else begin
                sdiv_nxt = '0;
                if (in_data.key_pause_down) begin
                  if (pcnt_r < dbcnt_r) pcnt_nxt = pcnt_r + 3'd1;
                  else if (!plock_r) begin
                    plock_nxt = 1'b1;
                    pause_nxt = !pause_r;
                  end
                end else begin
                  pcnt_nxt = '0;
                  plock_nxt = 1'b0;
                end
                if (in_data.key_speed_down) begin
                  if (scnt_r < dbcnt_r) scnt_nxt = scnt_r + 3'd1;
                  else if (!slock_r) begin
                    slock_nxt = 1'b1;
                    speed_nxt = speed_r + 2'd1;
                  end
                end else begin
                  scnt_nxt = '0;
                  slock_nxt = 1'b0;
                end
              end
              if (!pause_nxt && mode_r != MODE_END) acc_nxt = acc_r + SPEED_STEPS[speed_nxt];
              state_nxt = S_SUB;
            end
            default: ;
          endcase
        end
      end

      // Total time: one store read and one multiply-add per entry.
      S_TOT_RD: begin
        if (idx_r < entry_count_r) begin
          state_nxt = S_TOT_ACC;
        end else begin
          total_nxt = (sum_r == 32'd0) ? 32'd1 : sum_r;
          state_nxt = S_LD_RD;
        end
      end
      S_TOT_ACC: begin
        sum_nxt = sum_r + {16'd0, unit_prod} + {24'd0, gap_cfg_r};
        idx_nxt = idx_r + 1'b1;
        state_nxt = S_TOT_RD;
      end

      // Load the next note, or end the score.
      S_LD_RD: begin
        if (read_pos_r >= entry_count_r) begin
          mode_nxt = MODE_END;
          note_nxt = '0;
          played_nxt = total_nxt;
          state_nxt = S_SUB;
        end else begin
          state_nxt = S_LD_APPLY;
        end
      end
      S_LD_APPLY: begin
        read_pos_nxt = read_pos_r + 1'b1;
        note_nxt = rd_data_r[15:8];
        note_left_nxt = unit_prod;
        gap_left_nxt = gap_cfg_r;
        mode_nxt = MODE_NOTE;
        state_nxt = S_SUB;
      end

      // One millisecond substep per pass while the accumulator holds two halves.
      S_SUB: begin
        if (acc_r >= 4'd2) begin
          acc_nxt = acc_r - 4'd2;
          unique case (mode_r)
            MODE_LOAD: state_nxt = S_LD_RD;
            MODE_NOTE: begin
              if (note_left_r != 16'd0) begin
                note_left_nxt = note_left_r - 16'd1;
                if (played_r < total_r) played_nxt = played_r + 32'd1;
              end
              if (note_left_r <= 16'd1) mode_nxt = MODE_GAP;
            end
            MODE_GAP: begin
              if (gap_left_r != 8'd0) begin
                gap_left_nxt = gap_left_r - 8'd1;
                if (played_r < total_r) played_nxt = played_r + 32'd1;
              end
              if (gap_left_r <= 8'd1) state_nxt = S_LD_RD;
            end
            default: ;
          endcase
        end else begin
          state_nxt = S_PCT_MUL;
        end
      end

      // Percent: numerator with rounding, then restoring division one bit a cycle; end mode takes full scale.
      S_PCT_MUL: begin
        num_nxt = pct_prod + {8'd0, total_r[31:1]};
        quo_nxt = '0;
        bit_nxt = 3'd6;
        state_nxt = (mode_r == MODE_END) ? S_DONE : S_PCT_DIV;
        if (mode_r == MODE_END) quo_nxt = PCT_SCALE;
      end
      S_PCT_DIV: begin
        if (num_r >= trial) begin
          num_nxt = num_r - trial;
          quo_nxt[bit_r] = 1'b1;
        end
        if (bit_r == 3'd0) state_nxt = S_DONE;
        else bit_nxt = bit_r - 3'd1;
      end

      // Result transfer.
      S_DONE: begin
        out_valid_nxt = 1'b1;
        out_data_nxt.note_out = note_r;
        out_data_nxt.tone_on = (mode_r == MODE_NOTE) && !pause_r && (note_r != rest_r);
        out_data_nxt.mode = mode_r;
        out_data_nxt.is_paused = pause_r;
        out_data_nxt.percent = (quo_r > PCT_SCALE) ? PCT_SCALE : quo_r;
        out_data_nxt.speed_level = {1'b0, speed_r} + 3'd1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      unit_r <= 8'd125;  gap_cfg_r <= 8'd5;  rest_r <= 8'd0;
      period_r <= 4'd5;  dbcnt_r <= 3'd4;
      entry_count_r <= '0; read_pos_r <= '0; idx_r <= '0;
      mode_r <= MODE_LOAD; pause_r <= 1'b0; note_r <= '0;
      note_left_r <= '0; gap_left_r <= '0;
      played_r <= '0;    total_r <= 32'd1;  sum_r <= '0;
      speed_r <= 2'd1;   acc_r <= '0;       sdiv_r <= '0;
      pcnt_r <= '0;      scnt_r <= '0;      plock_r <= 1'b0; slock_r <= 1'b0;
      bit_r <= '0;       out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      unit_r <= unit_nxt; gap_cfg_r <= gap_cfg_nxt; rest_r <= rest_nxt;
      period_r <= period_nxt; dbcnt_r <= dbcnt_nxt;
      entry_count_r <= entry_count_nxt; read_pos_r <= read_pos_nxt; idx_r <= idx_nxt;
      mode_r <= mode_nxt; pause_r <= pause_nxt; note_r <= note_nxt;
      note_left_r <= note_left_nxt; gap_left_r <= gap_left_nxt;
      played_r <= played_nxt; total_r <= total_nxt; sum_r <= sum_nxt;
      speed_r <= speed_nxt; acc_r <= acc_nxt; sdiv_r <= sdiv_nxt;
      pcnt_r <= pcnt_nxt; scnt_r <= scnt_nxt; plock_r <= plock_nxt; slock_r <= slock_nxt;
      bit_r <= bit_nxt; out_valid_r <= out_valid_nxt;
    end
    num_r <= num_nxt;
    quo_r <= quo_nxt;
    out_data_r <= out_data_nxt;
  end

  assign busy = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data = out_data_r;

endmodule

`default_nettype wire

@@ rtl/nsp_checker.sv @@
// Port-level checks for the note sequence player, bound to the top level.
// Depends on nsp_pkg and note_sequence_player_unit.
`timescale 1ns / 1ps
`default_nettype none

module nsp_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               start,
  input wire logic               busy,
  input wire nsp_pkg::in_item_t  in_data,
  input wire logic               out_valid,
  input wire nsp_pkg::out_item_t out_data
);
  import nsp_pkg::*;

  // An accepted transfer keeps the block busy in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("busy not raised after transfer");

  // A result ends the work on its item.
  a_idle_with_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("result strobed while busy");

  // End mode reports full progress and no note.
  a_end_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.mode == MODE_END) |->
      (out_data.percent == PCT_SCALE && out_data.note_out == 8'd0))
    else $error("bad end status");

  // Tone only sounds while a note plays unpaused.
  a_tone_rule: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.tone_on) |->
      (out_data.mode == MODE_NOTE && !out_data.is_paused))
    else $error("tone outside note mode");

  // Progress never exceeds full scale.
  a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.percent <= PCT_SCALE)) else $error("percent out of range");

endmodule

bind note_sequence_player_unit nsp_checker u_nsp_checker (.*);

`default_nettype wire
